// ===== design/rgb_test_pattern_generator_unit_assert.svh =====
// Assertion macros for the RGB test pattern generator.
// Uses the clk and arst_n names of the module that expands them.
`ifndef RGB_TEST_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define RGB_TEST_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTPG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rtpg assertion failed");
`define RTPG_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rtpg assertion failed");
`else
`define RTPG_ASSERT(label, prop)
`define RTPG_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== design/rtpg_pkg.sv =====
// Shared types, constants and pixel packing functions of the RGB test pattern generator.
// No dependencies.
package rtpg_pkg;

	localparam int CROSS_HALF = 50;
	localparam int MAX_DIM    = 4096;
	localparam int MIN_DIM    = 16;
	localparam int MAX_BITS   = 8;
	localparam int MAX_SHIFT  = 24;
	localparam int EDGE_MARK  = 5;
	localparam int DIAG_SPAN  = 4;

	localparam int POS_W      = 12;
	localparam int DIM_W      = 13;
	localparam int BITS_W     = 4;
	localparam int SHIFT_W    = 5;
	localparam int BAND_W     = 6;
	localparam int GREY_W     = 5;
	localparam int PIX_W      = 32;
	localparam int LVL_W      = 8;
	localparam int QUO_W      = 5;
	localparam int DIV_W      = 17;
	localparam int CNT_W      = 3;
	localparam int SXY_W      = DIM_W + 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;

	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [BAND_W-1:0] BAND_NONE = '1;
	localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(3 * MAX_BITS + 2);
	localparam logic [GREY_W-1:0] GREY_LAST = GREY_W'(MAX_BITS + 2);

	localparam logic [LVL_W-1:0] LVL_BLACK = 8'd0;
	localparam logic [LVL_W-1:0] LVL_HALF  = 8'd127;
	localparam logic [LVL_W-1:0] LVL_FULL  = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 4'd0,
		CFG_HEIGHT = 4'd1,
		CFG_RBITS  = 4'd2,
		CFG_GBITS  = 4'd3,
		CFG_BBITS  = 4'd4,
		CFG_RSHIFT = 4'd5,
		CFG_GSHIFT = 4'd6,
		CFG_BSHIFT = 4'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

	// Clamped configuration plus values derived from it
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [BITS_W-1:0]  rl;
		logic [BITS_W-1:0]  gl;
		logic [BITS_W-1:0]  bl;
		logic [SHIFT_W-1:0] rs;
		logic [SHIFT_W-1:0] gs;
		logic [SHIFT_W-1:0] bs;
		logic [QUO_W-1:0]   p1;
		logic [QUO_W-1:0]   p2;
		logic [QUO_W-1:0]   p3;
		logic [BITS_W-1:0]  ml;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             le;
		logic             fe;
	} item_t;

	function automatic logic [PIX_W-1:0] chan(input logic [LVL_W-1:0] v,
			input logic [BITS_W-1:0] len, input logic [SHIFT_W-1:0] sh);
		logic [LVL_W:0]   mask;
		logic [LVL_W-1:0] f;
		mask = (9'd1 << len) - 9'd1;
		if (v == '0) begin
			f = '0;
		end else if (v <= LVL_W'(len)) begin
			f = LVL_W'(1) << (v - LVL_W'(1));
		end else begin
			f = mask[LVL_W-1:0];
		end
		return PIX_W'(f) << sh;
	endfunction

	function automatic logic [PIX_W-1:0] rgb(input logic [LVL_W-1:0] r,
			input logic [LVL_W-1:0] g, input logic [LVL_W-1:0] b, input cfg_t c);
		return chan(r, c.rl, c.rs) | chan(g, c.gl, c.gs) | chan(b, c.bl, c.bs);
	endfunction

endpackage

// ===== design/rtpg_cfg.sv =====
// Configuration registers of the RGB test pattern generator, clamped on write.
// Depends on rtpg_pkg.
module rtpg_cfg import rtpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [DIM_W-1:0]   width_q, height_q;
	logic [BITS_W-1:0]  rl_q, gl_q, bl_q;
	logic [SHIFT_W-1:0] rs_q, gs_q, bs_q;
	logic [BITS_W-1:0]  min_rg, min_all;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
		if (d < DIM_W'(MIN_DIM)) begin
			return DIM_W'(MIN_DIM);
		end else if (d > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return d;
	endfunction

	function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] d);
		if (d == '0) begin
			return BITS_W'(1);
		end else if (d > BITS_W'(MAX_BITS)) begin
			return BITS_W'(MAX_BITS);
		end
		return d;
	endfunction

	function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] d);
		return (d > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			rl_q     <= 4'd5;
			gl_q     <= 4'd6;
			bl_q     <= 4'd5;
			rs_q     <= 5'd11;
			gs_q     <= 5'd5;
			bs_q     <= 5'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= clamp_dim(cfg_data);
				CFG_HEIGHT: height_q <= clamp_dim(cfg_data);
				CFG_RBITS:  rl_q     <= clamp_bits(cfg_data[BITS_W-1:0]);
				CFG_GBITS:  gl_q     <= clamp_bits(cfg_data[BITS_W-1:0]);
				CFG_BBITS:  bl_q     <= clamp_bits(cfg_data[BITS_W-1:0]);
				CFG_RSHIFT: rs_q     <= clamp_shift(cfg_data[SHIFT_W-1:0]);
				CFG_GSHIFT: gs_q     <= clamp_shift(cfg_data[SHIFT_W-1:0]);
				CFG_BSHIFT: bs_q     <= clamp_shift(cfg_data[SHIFT_W-1:0]);
				default: ;
			endcase
		end
	end

	assign min_rg  = (rl_q < gl_q) ? rl_q : gl_q;
	assign min_all = (min_rg < bl_q) ? min_rg : bl_q;

	always_comb begin
		cfg.width  = width_q;
		cfg.height = height_q;
		cfg.rl     = rl_q;
		cfg.gl     = gl_q;
		cfg.bl     = bl_q;
		cfg.rs     = rs_q;
		cfg.gs     = gs_q;
		cfg.bs     = bs_q;
		// band boundaries: red bands, then green, then blue
		cfg.p1     = QUO_W'(rl_q) + QUO_W'(1);
		cfg.p2     = QUO_W'(rl_q) + QUO_W'(gl_q) + QUO_W'(2);
		cfg.p3     = QUO_W'(rl_q) + QUO_W'(gl_q) + QUO_W'(bl_q) + QUO_W'(3);
		cfg.ml     = min_all + BITS_W'(1);
	end

endmodule

// ===== design/rtpg_front.sv =====
// Front end: accepts pixel ticks and walks the raster counters.
// Depends on rtpg_pkg; feeds rtpg_queue.
module rtpg_front import rtpg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  push,
	input  logic  restart_frame,
	output logic  full,
	output logic  q_wr,
	output item_t q_item,
	input  logic  q_full
);

	logic [POS_W-1:0] col_q, row_q;
	logic [POS_W-1:0] x, y;
	logic             le, fe;

	always_comb begin
		x = restart_frame ? '0 : col_q;
		y = restart_frame ? '0 : row_q;
		// counters left beyond a shrunk frame restart at zero
		if (DIM_W'(x) >= cfg.width) begin
			x = '0;
		end
		if (DIM_W'(y) >= cfg.height) begin
			y = '0;
		end
		le = (DIM_W'(x) + DIM_W'(1)) == cfg.width;
		fe = le && ((DIM_W'(y) + DIM_W'(1)) == cfg.height);
	end

	assign full        = q_full;
	assign q_wr        = push && !q_full;
	assign q_item.x    = x;
	assign q_item.y    = y;
	assign q_item.le   = le;
	assign q_item.fe   = fe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_wr) begin
			if (le) begin
				col_q <= '0;
				row_q <= fe ? '0 : y + POS_W'(1);
			end else begin
				col_q <= x + POS_W'(1);
				row_q <= y;
			end
		end
	end

endmodule

// ===== design/rtpg_queue.sv =====
// Short item queue between the front and back ends.
// Depends on rtpg_pkg.
module rtpg_queue import rtpg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	output logic  full,
	input  logic  rd,
	output item_t rdata,
	output logic  empty
);

	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr, do_rd;

	assign full   = count_q == QCNT_W'(QDEPTH);
	assign empty  = count_q == '0;
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/rtpg_back.sv =====
// Back end: per-row band/grey divider, pixel pattern logic and output register.
// Depends on rtpg_pkg and the assertion macro header.
`include "rgb_test_pattern_generator_unit_assert.svh"

module rtpg_back import rtpg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  item_t            q_item,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [PIX_W-1:0] pixel_value,
	output logic [POS_W-1:0] column,
	output logic [POS_W-1:0] row,
	output logic             line_end,
	output logic             frame_end
);

	localparam logic signed [SXY_W-1:0] CR_HALF = SXY_W'(CROSS_HALF);
	localparam logic signed [SXY_W-1:0] CR_MARK = SXY_W'(CROSS_HALF - EDGE_MARK);

	bk_state_t         state_q, state_d;
	item_t             item_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [DIV_W-1:0]  rem_band_q, rem_grey_q, dsr_q;
	logic [QUO_W-1:0]  quo_band_q, quo_grey_q;
	logic [BAND_W-1:0] prev_band_q, row_band_q;
	logic [GREY_W-1:0] row_grey_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_q;
	logic [POS_W-1:0]  column_q, row_q;
	logic              line_end_q, frame_end_q;

	logic              load_out, start_div;
	logic              band_ge, grey_ge;
	logic [QUO_W-1:0]  band_quo_d, grey_quo_d;

	// pixel pattern signals
	logic [DIM_W-1:0]        x13, y13, hx, hy;
	logic                    first_row, last_row, x_lo, x_hi;
	logic                    edge_hit, edge_odd, border_hit, border_blk, band_hit;
	logic signed [SXY_W-1:0] dx, dy;
	logic                    in_cross, toggle, cross_white, diag, left_half, grey_over;
	logic [BAND_W-1:0]       p1e, p2e, p3e;
	logic [LVL_W-1:0]        band_r, band_g, band_b, lv_r, lv_g, lv_b;
	logic [GREY_W-1:0]       grey_r, grey_g, grey_b;
	logic [PIX_W-1:0]        pixel_d;

	// ---------------- control ----------------
	always_comb begin
		state_d   = state_q;
		q_rd      = 1'b0;
		start_div = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					if (q_item.x == '0) begin
						start_div = 1'b1;
						state_d   = BK_DIV;
					end else begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- row divider ----------------
	// restoring division, one quotient bit per cycle for both row values
	assign band_ge    = rem_band_q >= dsr_q;
	assign grey_ge    = rem_grey_q >= dsr_q;
	assign band_quo_d = {quo_band_q[QUO_W-2:0], band_ge};
	assign grey_quo_d = {quo_grey_q[QUO_W-2:0], grey_ge};

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
		if (start_div) begin
			rem_band_q <= DIV_W'(q_item.y) * DIV_W'(cfg.p3);
			rem_grey_q <= DIV_W'(q_item.y) * (DIV_W'(cfg.ml) + DIV_W'(1));
			dsr_q      <= DIV_W'(cfg.height) << (QUO_W - 1);
			div_cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (state_q == BK_DIV) begin
			rem_band_q <= band_ge ? rem_band_q - dsr_q : rem_band_q;
			rem_grey_q <= grey_ge ? rem_grey_q - dsr_q : rem_grey_q;
			quo_band_q <= band_quo_d;
			quo_grey_q <= grey_quo_d;
			dsr_q      <= dsr_q >> 1;
			div_cnt_q  <= div_cnt_q - CNT_W'(1);
		end
		if (load_out) begin
			pixel_q     <= pixel_d;
			column_q    <= item_q.x;
			row_q       <= item_q.y;
			line_end_q  <= item_q.le;
			frame_end_q <= item_q.fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_band_q <= BAND_NONE;
			row_band_q  <= '0;
			row_grey_q  <= GREY_W'(1);
		end else begin
			if (start_div) begin
				prev_band_q <= (q_item.y == '0) ? BAND_NONE : row_band_q;
			end
			if (state_q == BK_DIV && div_cnt_q == '0) begin
				row_band_q <= BAND_W'(band_quo_d);
				row_grey_q <= grey_quo_d + GREY_W'(1);
			end
		end
	end

	// ---------------- pixel pattern ----------------
	always_comb begin
		x13        = DIM_W'(item_q.x);
		y13        = DIM_W'(item_q.y);
		hx         = cfg.width >> 1;
		hy         = cfg.height >> 1;
		first_row  = item_q.y == '0;
		last_row   = (y13 + DIM_W'(1)) == cfg.height;
		x_lo       = x13 < DIM_W'(EDGE_MARK);
		x_hi       = x13 >= (cfg.width - DIM_W'(EDGE_MARK));
		edge_hit   = (first_row || last_row) && (x_lo || x_hi);
		// right-hand marks count from width-5, so their parity follows the width
		edge_odd   = x_lo ? item_q.x[0] : ~(item_q.x[0] ^ cfg.width[0]);

		border_hit = !first_row && !last_row &&
			(y13 < DIM_W'(EDGE_MARK) || (y13 + DIM_W'(EDGE_MARK)) >= cfg.height) &&
			(item_q.x == '0 || (x13 + DIM_W'(1)) == cfg.width);
		border_blk = (y13 < hy && item_q.y[0]) ||
			(y13 > hy && ~(cfg.height[0] ^ item_q.y[0]));

		p1e        = BAND_W'(cfg.p1);
		p2e        = BAND_W'(cfg.p2);
		p3e        = BAND_W'(cfg.p3);
		band_hit   = y13 >= DIM_W'(EDGE_MARK) && (y13 + DIM_W'(EDGE_MARK)) < cfg.height &&
			x13 < DIM_W'(2) && row_band_q != prev_band_q &&
			(row_band_q == '0 || row_band_q == p1e || row_band_q == p2e);

		dx         = $signed({2'b00, hx}) - $signed({3'b000, item_q.x});
		dy         = $signed({2'b00, hy}) - $signed({3'b000, item_q.y});
		in_cross   = dx <= CR_HALF && dx > -CR_HALF && dy <= CR_HALF && dy > -CR_HALF;
		toggle     = dx == dy || dx == -dy ||
			dx == -CR_MARK || dx == CR_MARK - SXY_W'(1) ||
			dy == -CR_MARK || dy == CR_MARK - SXY_W'(1);
		cross_white = toggle ^ dy[SXY_W-1];

		diag       = item_q.y < POS_W'(DIAG_SPAN) && item_q.x == (POS_W'(DIAG_SPAN) - item_q.y);
		left_half  = x13 < hx;
		grey_over  = row_grey_q > GREY_W'(cfg.ml);

		band_r     = (row_band_q < p1e) ? LVL_W'(row_band_q) + LVL_W'(1) : LVL_BLACK;
		band_g     = (row_band_q >= p1e && row_band_q < p2e) ?
			LVL_W'(row_band_q - p1e) + LVL_W'(1) : LVL_BLACK;
		band_b     = (row_band_q >= p2e && row_band_q < p3e) ?
			LVL_W'(row_band_q - p2e) + LVL_W'(1) : LVL_BLACK;

		grey_r     = row_grey_q + GREY_W'(cfg.rl) - GREY_W'(cfg.ml);
		grey_g     = row_grey_q + GREY_W'(cfg.gl) - GREY_W'(cfg.ml);
		grey_b     = row_grey_q + GREY_W'(cfg.bl) - GREY_W'(cfg.ml);

		if (edge_hit) begin
			lv_r = edge_odd ? LVL_BLACK : LVL_FULL;
			lv_g = lv_r;
			lv_b = lv_r;
		end else if (border_hit) begin
			lv_r = border_blk ? LVL_BLACK : LVL_FULL;
			lv_g = lv_r;
			lv_b = lv_r;
		end else if (band_hit) begin
			lv_r = LVL_HALF;
			lv_g = LVL_HALF;
			lv_b = LVL_HALF;
		end else if (in_cross) begin
			lv_r = cross_white ? LVL_FULL : LVL_BLACK;
			lv_g = lv_r;
			lv_b = lv_r;
		end else if (diag) begin
			lv_r = LVL_FULL;
			lv_g = LVL_FULL;
			lv_b = LVL_FULL;
		end else if (left_half) begin
			lv_r = band_r;
			lv_g = band_g;
			lv_b = band_b;
		end else if (grey_over) begin
			lv_r = LVL_FULL;
			lv_g = LVL_FULL;
			lv_b = LVL_FULL;
		end else begin
			lv_r = LVL_W'(grey_r);
			lv_g = LVL_W'(grey_g);
			lv_b = LVL_W'(grey_b);
		end
		pixel_d = rgb(lv_r, lv_g, lv_b, cfg);
	end

	assign empty       = !out_valid_q;
	assign pixel_value = pixel_q;
	assign column      = column_q;
	assign row         = row_q;
	assign line_end    = line_end_q;
	assign frame_end   = frame_end_q;

	// row band is a quotient below the band count, grey level at most min width + 2
	`RTPG_ASSERT(a_band_range, row_band_q <= BAND_LAST)
	`RTPG_ASSERT(a_grey_range, row_grey_q >= GREY_W'(1) && row_grey_q <= GREY_LAST)
	`RTPG_ASSERT_NEXT(a_div_done, state_q == BK_DIV && div_cnt_q == '0, state_q == BK_EMIT)
	`RTPG_ASSERT_NEXT(a_emit_wait, state_q == BK_EMIT && out_valid_q && !pop, state_q == BK_EMIT)

endmodule

// ===== design/rgb_test_pattern_generator_unit.sv =====
// Top level of the RGB test pattern generator: config registers, front end, item queue,
// back end. Depends on rtpg_pkg, rtpg_cfg, rtpg_front, rtpg_queue and rtpg_back.
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------------------------
//  input     push / full        restart_frame
//  result    pop / empty        pixel_value, column, row, line_end, frame_end
//  config    cfg_wr_en          cfg_index, cfg_data
//
// The front end takes one tick per cycle into a 2-entry queue while there is room.
// The back end reads each pixel from the queue, then builds its pattern; at column 0 it
// first divides, as the row band and grey level go through a 5-step restoring divider.
// A finished pixel sits in the output register until popped; the back end waits in its
// build state meanwhile and the queue fills behind it. Asynchronous reset restores the
// default configuration and the top-left raster position; there is no clearing pass.
module rgb_test_pattern_generator_unit import rtpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  restart_frame,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_W-1:0]      pixel_value,
	output logic [POS_W-1:0]      column,
	output logic [POS_W-1:0]      row,
	output logic                  line_end,
	output logic                  frame_end,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	logic  q_wr, q_full, q_rd, q_empty;
	item_t q_wdata, q_rdata;

	rtpg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rtpg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.push          (push),
		.restart_frame (restart_frame),
		.full          (full),
		.q_wr          (q_wr),
		.q_item        (q_wdata),
		.q_full        (q_full)
	);

	rtpg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	rtpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.q_item      (q_rdata),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.pixel_value (pixel_value),
		.column      (column),
		.row         (row),
		.line_end    (line_end),
		.frame_end   (frame_end)
	);

endmodule
